/* rtl/rk4_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the RK4 linear ODE step core.
// No dependencies; imported by rk4_kstage and rk4_linear_ode_step_core.
package rk4_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Register index codes on the configuration port
    localparam logic [1:0] REG_STEP   = 2'd0;
    localparam logic [1:0] REG_COEF_X = 2'd1;
    localparam logic [1:0] REG_COEF_Y = 2'd2;
    localparam logic [1:0] REG_COEF_V = 2'd3;

    // Control that travels alongside each item in the stage pipeline
    typedef struct packed {
        logic valid;
        logic ovf;
    } stg_ctl_t;

endpackage

/* rtl/rk4_kstage.sv */
`timescale 1ns / 1ps
// One Runge-Kutta slope evaluation: k = h*v, l = h*(cx*x + cy*y + cv*v).
// Seven register stages; depends on rk4_pkg.
module rk4_kstage #(
    parameter int DATA_WIDTH = rk4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rk4_pkg::FRAC_BITS_DEF,
    parameter int CARRY_W    = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rk4_pkg::stg_ctl_t             ctl_in,
    input  logic [DATA_WIDTH-2:0]         step_size,
    input  logic signed [DATA_WIDTH-1:0]  coef_x,
    input  logic signed [DATA_WIDTH-1:0]  coef_y,
    input  logic signed [DATA_WIDTH-1:0]  coef_v,
    input  logic signed [DATA_WIDTH-1:0]  x_arg,
    input  logic signed [DATA_WIDTH-1:0]  y_arg,
    input  logic signed [DATA_WIDTH-1:0]  v_arg,
    input  logic [CARRY_W-1:0]            carry_in,
    output rk4_pkg::stg_ctl_t             ctl_out,
    output logic [DATA_WIDTH-1:0]         k_out,
    output logic [DATA_WIDTH-1:0]         l_out,
    output logic [CARRY_W-1:0]            carry_out
);
    import rk4_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int DEPTH = 7;

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    // Shift the exact product down and clamp; top bit flags a clamp
    function automatic logic [W:0] sat_prod(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] s;
        logic [W:0] r;
        s = p >>> FRAC_BITS;
        if (s[2*W-1:W-1] == {(W+1){s[2*W-1]}})
            r = {1'b0, s[W-1:0]};
        else
            r = {1'b1, (s[2*W-1] ? SMIN : SMAX)};
        return r;
    endfunction

    function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        logic [W:0] r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] == s[W-1])
            r = {1'b0, s[W-1:0]};
        else
            r = {1'b1, (s[W] ? SMIN : SMAX)};
        return r;
    endfunction

    stg_ctl_t               ctl_reg   [DEPTH];
    logic [CARRY_W-1:0]     carry_reg [DEPTH];

    logic signed [W-1:0]    xa_reg, ya_reg, va_reg;
    logic signed [2*W-1:0]  px_reg, py_reg, pv_reg, pk_reg;
    logic [W-1:0]           sx_reg, sy_reg, sv_reg, k3_reg;
    logic [W-1:0]           sum1_reg, sv4_reg, k4_reg;
    logic [W-1:0]           acc_reg, k5_reg;
    logic signed [2*W-1:0]  pl_reg;
    logic [W-1:0]           k6_reg, kq_reg, lq_reg;

    logic signed [W-1:0]    h_s;
    logic [W:0]             sx_next, sy_next, sv_next, k3_next;
    logic [W:0]             sum1_next, acc_next, l_next;

    assign h_s = {1'b0, step_size};

    always_comb
    begin
        sx_next   = sat_prod(px_reg);
        sy_next   = sat_prod(py_reg);
        sv_next   = sat_prod(pv_reg);
        k3_next   = sat_prod(pk_reg);
        sum1_next = sat_add(sx_reg, sy_reg);
        acc_next  = sat_add(sum1_reg, sv4_reg);
        l_next    = sat_prod(pl_reg);
    end

    // Control: advance valid and fold in clamp flags where they arise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0]       <= ctl_in;
            ctl_reg[1]       <= ctl_reg[0];
            ctl_reg[2].valid <= ctl_reg[1].valid;
            ctl_reg[2].ovf   <= ctl_reg[1].ovf | sx_next[W] | sy_next[W]
                                | sv_next[W] | k3_next[W];
            ctl_reg[3].valid <= ctl_reg[2].valid;
            ctl_reg[3].ovf   <= ctl_reg[2].ovf | sum1_next[W];
            ctl_reg[4].valid <= ctl_reg[3].valid;
            ctl_reg[4].ovf   <= ctl_reg[3].ovf | acc_next[W];
            ctl_reg[5]       <= ctl_reg[4];
            ctl_reg[6].valid <= ctl_reg[5].valid;
            ctl_reg[6].ovf   <= ctl_reg[5].ovf | l_next[W];
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg[0] <= carry_in;
        for (int i = 1; i < DEPTH; i++)
        begin
            carry_reg[i] <= carry_reg[i-1];
        end
        xa_reg   <= x_arg;
        ya_reg   <= y_arg;
        va_reg   <= v_arg;
        px_reg   <= coef_x * xa_reg;
        py_reg   <= coef_y * ya_reg;
        pv_reg   <= coef_v * va_reg;
        pk_reg   <= h_s * va_reg;
        sx_reg   <= sx_next[W-1:0];
        sy_reg   <= sy_next[W-1:0];
        sv_reg   <= sv_next[W-1:0];
        k3_reg   <= k3_next[W-1:0];
        sum1_reg <= sum1_next[W-1:0];
        sv4_reg  <= sv_reg;
        k4_reg   <= k3_reg;
        acc_reg  <= acc_next[W-1:0];
        k5_reg   <= k4_reg;
        pl_reg   <= h_s * $signed(acc_reg);
        k6_reg   <= k5_reg;
        kq_reg   <= k6_reg;
        lq_reg   <= l_next[W-1:0];
    end

    assign ctl_out   = ctl_reg[DEPTH-1];
    assign carry_out = carry_reg[DEPTH-1];
    assign k_out     = kq_reg;
    assign l_out     = lq_reg;

endmodule

/* rtl/rk4_linear_ode_step_core.sv */
`timescale 1ns / 1ps
// Top level of the RK4 linear ODE step core: APB registers, four slope
// pipelines and the weighted update. Depends on rk4_pkg and rk4_kstage.
//
// Takes a point (pos_x, val_y, slope_v) in signed fixed point and returns
// the point after one classical fourth-order Runge-Kutta step of
// y' = v, v' = coef_x*x + coef_y*y + coef_v*v with step step_size. The core
// is a fully pipelined datapath: busy is never raised, so a new point may be
// transferred on every clock, and each result appears for one cycle, flagged
// by done. The latency is set by the input register, the four chained slope
// evaluations (seven stages each, two multipliers deep) and the final update
// with its divide-by-six reciprocal multiply. Results
// cannot be held off, so capture them on the cycle done is high. overflow
// reports that any product, sum or final value was clamped during the step.
// Write step_size and the coefficients over APB only while no step is in
// flight; register i sits at byte address 4*i (8*i for 64-bit data).
module rk4_linear_ode_step_core #(
    parameter int DATA_WIDTH = rk4_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rk4_pkg::FRAC_BITS_DEF,
    localparam int PW = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int AW = (DATA_WIDTH > 32) ? 5 : 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [AW-1:0]          paddr,
    input  logic [PW-1:0]          pwdata,
    output logic [PW-1:0]          prdata,
    output logic                   pready,
    input  logic                   start,
    output logic                   busy,
    input  logic [DATA_WIDTH-1:0]  pos_x,
    input  logic [DATA_WIDTH-1:0]  val_y,
    input  logic [DATA_WIDTH-1:0]  slope_v,
    output logic                   done,
    output logic [DATA_WIDTH-1:0]  next_x,
    output logic [DATA_WIDTH-1:0]  next_y,
    output logic [DATA_WIDTH-1:0]  next_v,
    output logic                   overflow
);
    import rk4_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int SW   = W + 3;          // exact weighted sum
    localparam int NW   = W + 1;          // half magnitude of the sum
    localparam int RW   = W + 2;          // reciprocal width and shift
    localparam int PRW  = NW + RW;        // reciprocal product
    localparam int LAT  = 34;

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [W-2:0] STEP_RST = (W-1)'(1) << (FRAC_BITS - 1);
    localparam logic [W-1:0] CX_RST   = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] CY_RST   = W'(0) - (W'(2) << FRAC_BITS);
    localparam logic [W-1:0] CV_RST   = W'(3) << FRAC_BITS;

    // floor(2^RW / 3): alternating ones from bit RW-2 downwards
    function automatic logic [RW-1:0] recip3();
        logic [RW-1:0] r;
        r = '0;
        for (int i = 0; i < RW - 1; i++)
        begin
            r[i] = ((RW - i) % 2 == 0);
        end
        return r;
    endfunction

    localparam logic [RW-1:0] RECIP3 = recip3();

    function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        logic [W:0] r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] == s[W-1])
            r = {1'b0, s[W-1:0]};
        else
            r = {1'b1, (s[W] ? SMIN : SMAX)};
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [W-2:0] step_reg;
    logic [W-1:0] cx_reg, cy_reg, cv_reg;
    logic [1:0]   reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AW-1:AW-2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RST;
            cx_reg   <= CX_RST;
            cy_reg   <= CY_RST;
            cv_reg   <= CV_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STEP:   step_reg <= pwdata[W-2:0];
                REG_COEF_X: cx_reg   <= pwdata[W-1:0];
                REG_COEF_Y: cy_reg   <= pwdata[W-1:0];
                REG_COEF_V: cv_reg   <= pwdata[W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STEP:   prdata = PW'(step_reg);
            REG_COEF_X: prdata = PW'(cx_reg);
            REG_COEF_Y: prdata = PW'(cy_reg);
            REG_COEF_V: prdata = PW'(cv_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input capture and the x end/mid points
    // ---------------------------------------------------------------
    assign busy = 1'b0;

    logic         in_valid_reg;
    logic [W-1:0] x_reg, y_reg, v_reg;
    logic [W:0]   nx0, xm0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= pos_x;
        y_reg <= val_y;
        v_reg <= slope_v;
    end

    assign nx0 = sat_add(x_reg, {1'b0, step_reg});
    assign xm0 = sat_add(x_reg, {2'b00, step_reg[W-2:1]});

    // ---------------------------------------------------------------
    // Four chained slope evaluations
    // ---------------------------------------------------------------
    stg_ctl_t     c1_in, c1_out, c2_in, c2_out, c3_in, c3_out, c4_in, c4_out;
    logic [4*W-1:0] cr1_in, cr1_out;
    logic [6*W-1:0] cr2_in, cr2_out;
    logic [8*W-1:0] cr3_in, cr3_out;
    logic [9*W-1:0] cr4_in, cr4_out;
    logic [W-1:0]   k1, l1, k2, l2, k3, l3, k4, l4;
    logic [W:0]     ya2, va2, ya3, va3, ya4, va4;

    assign c1_in.valid = in_valid_reg;
    assign c1_in.ovf   = nx0[W] | xm0[W];
    assign cr1_in      = {y_reg, v_reg, nx0[W-1:0], xm0[W-1:0]};

    rk4_kstage #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CARRY_W(4*W)) u_stage1 (
        .clk(clk), .rst_n(rst_n), .ctl_in(c1_in), .step_size(step_reg),
        .coef_x(cx_reg), .coef_y(cy_reg), .coef_v(cv_reg),
        .x_arg(x_reg), .y_arg(y_reg), .v_arg(v_reg), .carry_in(cr1_in),
        .ctl_out(c1_out), .k_out(k1), .l_out(l1), .carry_out(cr1_out)
    );

    // Second point: half of the first slopes
    assign ya2         = sat_add(cr1_out[4*W-1:3*W], {k1[W-1], k1[W-1:1]});
    assign va2         = sat_add(cr1_out[3*W-1:2*W], {l1[W-1], l1[W-1:1]});
    assign c2_in.valid = c1_out.valid;
    assign c2_in.ovf   = c1_out.ovf | ya2[W] | va2[W];
    assign cr2_in      = {cr1_out, k1, l1};

    rk4_kstage #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CARRY_W(6*W)) u_stage2 (
        .clk(clk), .rst_n(rst_n), .ctl_in(c2_in), .step_size(step_reg),
        .coef_x(cx_reg), .coef_y(cy_reg), .coef_v(cv_reg),
        .x_arg(cr1_out[W-1:0]), .y_arg(ya2[W-1:0]), .v_arg(va2[W-1:0]),
        .carry_in(cr2_in),
        .ctl_out(c2_out), .k_out(k2), .l_out(l2), .carry_out(cr2_out)
    );

    // Third point: half of the second slopes
    assign ya3         = sat_add(cr2_out[6*W-1:5*W], {k2[W-1], k2[W-1:1]});
    assign va3         = sat_add(cr2_out[5*W-1:4*W], {l2[W-1], l2[W-1:1]});
    assign c3_in.valid = c2_out.valid;
    assign c3_in.ovf   = c2_out.ovf | ya3[W] | va3[W];
    assign cr3_in      = {cr2_out, k2, l2};

    rk4_kstage #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CARRY_W(8*W)) u_stage3 (
        .clk(clk), .rst_n(rst_n), .ctl_in(c3_in), .step_size(step_reg),
        .coef_x(cx_reg), .coef_y(cy_reg), .coef_v(cv_reg),
        .x_arg(cr2_out[3*W-1:2*W]), .y_arg(ya3[W-1:0]), .v_arg(va3[W-1:0]),
        .carry_in(cr3_in),
        .ctl_out(c3_out), .k_out(k3), .l_out(l3), .carry_out(cr3_out)
    );

    // End point: full third slopes, drop the mid x from the carry
    assign ya4         = sat_add(cr3_out[8*W-1:7*W], k3);
    assign va4         = sat_add(cr3_out[7*W-1:6*W], l3);
    assign c4_in.valid = c3_out.valid;
    assign c4_in.ovf   = c3_out.ovf | ya4[W] | va4[W];
    assign cr4_in      = {cr3_out[8*W-1:5*W], cr3_out[4*W-1:0], k3, l3};

    rk4_kstage #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CARRY_W(9*W)) u_stage4 (
        .clk(clk), .rst_n(rst_n), .ctl_in(c4_in), .step_size(step_reg),
        .coef_x(cx_reg), .coef_y(cy_reg), .coef_v(cv_reg),
        .x_arg(cr3_out[6*W-1:5*W]), .y_arg(ya4[W-1:0]), .v_arg(va4[W-1:0]),
        .carry_in(cr4_in),
        .ctl_out(c4_out), .k_out(k4), .l_out(l4), .carry_out(cr4_out)
    );

    // ---------------------------------------------------------------
    // Weighted update: (s1 + 2 s2 + 2 s3 + s4) / 6 toward zero
    // ---------------------------------------------------------------
    logic [W-1:0] fy, fv, fnx, fk1, fl1, fk2, fl2, fk3, fl3;
    assign {fy, fv, fnx, fk1, fl1, fk2, fl2, fk3, fl3} = cr4_out;

    function automatic logic [SW-1:0] wsum(input logic [W-1:0] s1, input logic [W-1:0] s2,
                                           input logic [W-1:0] s3, input logic [W-1:0] s4);
        return {{3{s1[W-1]}}, s1} + {{2{s2[W-1]}}, s2, 1'b0}
             + {{2{s3[W-1]}}, s3, 1'b0} + {{3{s4[W-1]}}, s4};
    endfunction

    // Stage A: exact sums
    logic           a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, out_valid_reg;
    logic           a_ovf_reg, b_ovf_reg, c_ovf_reg, d_ovf_reg;
    logic [W-1:0]   a_y_reg, a_v_reg, a_nx_reg;
    logic [SW-1:0]  a_sy_reg, a_sv_reg;
    // Stage B: sign and half magnitude
    logic [W-1:0]   b_y_reg, b_v_reg, b_nx_reg;
    logic           b_ny_reg, b_nv_reg;
    logic [NW-1:0]  b_my_reg, b_mv_reg;
    // Stage C: reciprocal products
    logic [W-1:0]   c_y_reg, c_v_reg, c_nx_reg;
    logic           c_ny_reg, c_nv_reg;
    logic [NW-1:0]  c_my_reg, c_mv_reg;
    logic [PRW-1:0] c_py_reg, c_pv_reg;
    // Stage D: corrected quotients
    logic [W-1:0]   d_y_reg, d_v_reg, d_nx_reg, d_qy_reg, d_qv_reg;
    // Output
    logic [W-1:0]   nx_out_reg, ny_out_reg, nv_out_reg;
    logic           ovf_out_reg;

    logic [SW-1:0]  abs_y, abs_v;
    logic [NW-1:0]  q0y, q0v, qy, qv;
    logic [NW+1:0]  ry, rv;
    logic [NW-1:0]  wy, wv;
    logic [W:0]     ny_s, nv_s;

    always_comb
    begin
        abs_y = a_sy_reg[SW-1] ? (SW'(0) - a_sy_reg) : a_sy_reg;
        abs_v = a_sv_reg[SW-1] ? (SW'(0) - a_sv_reg) : a_sv_reg;
        q0y   = c_py_reg[PRW-1:RW];
        q0v   = c_pv_reg[PRW-1:RW];
        ry    = {2'b00, c_my_reg} - ({2'b00, q0y} + {1'b0, q0y, 1'b0});
        rv    = {2'b00, c_mv_reg} - ({2'b00, q0v} + {1'b0, q0v, 1'b0});
        qy    = (ry >= (NW+2)'(3)) ? (q0y + NW'(1)) : q0y;
        qv    = (rv >= (NW+2)'(3)) ? (q0v + NW'(1)) : q0v;
        wy    = c_ny_reg ? (NW'(0) - qy) : qy;
        wv    = c_nv_reg ? (NW'(0) - qv) : qv;
        ny_s  = sat_add(d_y_reg, d_qy_reg);
        nv_s  = sat_add(d_v_reg, d_qv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= c4_out.valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ovf_reg   <= c4_out.ovf;
        a_y_reg     <= fy;
        a_v_reg     <= fv;
        a_nx_reg    <= fnx;
        a_sy_reg    <= wsum(fk1, fk2, fk3, k4);
        a_sv_reg    <= wsum(fl1, fl2, fl3, l4);

        b_ovf_reg   <= a_ovf_reg;
        b_y_reg     <= a_y_reg;
        b_v_reg     <= a_v_reg;
        b_nx_reg    <= a_nx_reg;
        b_ny_reg    <= a_sy_reg[SW-1];
        b_nv_reg    <= a_sv_reg[SW-1];
        b_my_reg    <= abs_y[NW:1];
        b_mv_reg    <= abs_v[NW:1];

        c_ovf_reg   <= b_ovf_reg;
        c_y_reg     <= b_y_reg;
        c_v_reg     <= b_v_reg;
        c_nx_reg    <= b_nx_reg;
        c_ny_reg    <= b_ny_reg;
        c_nv_reg    <= b_nv_reg;
        c_my_reg    <= b_my_reg;
        c_mv_reg    <= b_mv_reg;
        c_py_reg    <= PRW'(b_my_reg) * PRW'(RECIP3);
        c_pv_reg    <= PRW'(b_mv_reg) * PRW'(RECIP3);

        d_ovf_reg   <= c_ovf_reg;
        d_y_reg     <= c_y_reg;
        d_v_reg     <= c_v_reg;
        d_nx_reg    <= c_nx_reg;
        d_qy_reg    <= wy[W-1:0];
        d_qv_reg    <= wv[W-1:0];

        nx_out_reg  <= d_nx_reg;
        ny_out_reg  <= ny_s[W-1:0];
        nv_out_reg  <= nv_s[W-1:0];
        ovf_out_reg <= d_ovf_reg | ny_s[W] | nv_s[W];
    end

    assign done     = out_valid_reg;
    assign next_x   = nx_out_reg;
    assign next_y   = ny_out_reg;
    assign next_v   = nv_out_reg;
    assign overflow = ovf_out_reg;

`ifndef SYNTH
    // Every accepted point comes out after the fixed pipeline latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted point did not produce a result on time");

    // No result appears without a matching accepted point
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted point");

    // Final slope pipeline and update stage stay in step
    a_stage_align: assert property (@(posedge clk) disable iff (!rst_n)
        c4_out.valid |=> ##4 done)
        else $error("update stages lost an item");
`endif

endmodule
